/* design/sm4_block_cipher_unit_defines.svh */
// Assertion macros shared by the SM4 block cipher RTL.
`ifndef SM4_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define SM4_BLOCK_CIPHER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SM4_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication with the consequent checked in the cycle after the antecedent.
`define SM4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* design/sm4_pkg.sv */
// Package with types, constants and functions of the SM4 block cipher.
`default_nettype none
package sm4_pkg;
    localparam int ROUNDS = 32;
    localparam int RIDX_W = $clog2(ROUNDS);
    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW = 2'd1;
    localparam logic [1:0] REG_CIPHER_MODE = 2'd2;
    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_word_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_word_t;

    typedef struct packed {
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] x3;
    } state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] v);
        tau = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    // Cipher round transform L applied after substitution.
    function automatic logic [31:0] t_data(input logic [31:0] v);
        logic [31:0] b;
        b = tau(v);
        t_data = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    // Key schedule transform L' applied after substitution.
    function automatic logic [31:0] t_key(input logic [31:0] v);
        logic [31:0] b;
        b = tau(v);
        t_key = b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // CK word i: byte j from the top is (4i+j)*7 mod 256.
    function automatic logic [31:0] ck_word(input logic [RIDX_W-1:0] i);
        logic [7:0] base;
        base = {i, 2'b00} * 8'd7;
        ck_word = {base, base + 8'd7, base + 8'd14, base + 8'd21};
    endfunction
endpackage
`default_nettype wire

/* design/sm4_round_cell.sv */
// One cipher round cell: applies one SM4 round and passes the block on.
`default_nettype none
`include "sm4_block_cipher_unit_defines.svh"
module sm4_round_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           valid,
    input  wire sm4_pkg::state_t data,
    input  wire logic [31:0]    round_key,
    output logic                valid_out,
    output sm4_pkg::state_t     data_out
);
    logic            valid_reg;
    sm4_pkg::state_t data_reg;
    sm4_pkg::state_t data_next;

    always_comb
    begin
        data_next.x0 = data.x1;
        data_next.x1 = data.x2;
        data_next.x2 = data.x3;
        data_next.x3 = data.x0 ^ sm4_pkg::t_data(data.x1 ^ data.x2 ^ data.x3 ^ round_key);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    `SM4_ASSERT_NEXT(a_valid_moves, clk, rst_n, valid, valid_out)
    `SM4_ASSERT_NEXT(a_idle_moves, clk, rst_n, !valid, !valid_out)
    `SM4_ASSERT_NEXT(a_shift, clk, rst_n, valid, data_out.x0 == $past(data.x1))
endmodule
`default_nettype wire

/* design/sm4_key_sched.sv */
// Key schedule: one round key per cycle into a register file, read by every round.
`default_nettype none
`include "sm4_block_cipher_unit_defines.svh"
module sm4_key_sched (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [63:0] key_high,
    input  wire logic [63:0] key_low,
    output logic             busy,
    output logic [31:0]      round_keys [sm4_pkg::ROUNDS]
);
    logic                      run_reg;
    logic [sm4_pkg::RIDX_W-1:0] idx_reg;
    sm4_pkg::state_t           k_reg;
    logic [31:0]               nk;
    logic [31:0]               rk_reg [sm4_pkg::ROUNDS];

    assign nk = k_reg.x0 ^ sm4_pkg::t_key(k_reg.x1 ^ k_reg.x2 ^ k_reg.x3
                                          ^ sm4_pkg::ck_word(idx_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b1;
            idx_reg <= '0;
            k_reg   <= {sm4_pkg::FK0, sm4_pkg::FK1, sm4_pkg::FK2, sm4_pkg::FK3};
        end
        else if (load)
        begin
            run_reg <= 1'b1;
            idx_reg <= '0;
            k_reg   <= {key_high[63:32] ^ sm4_pkg::FK0, key_high[31:0] ^ sm4_pkg::FK1,
                        key_low[63:32] ^ sm4_pkg::FK2, key_low[31:0] ^ sm4_pkg::FK3};
        end
        else if (run_reg)
        begin
            k_reg   <= {k_reg.x1, k_reg.x2, k_reg.x3, nk};
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == sm4_pkg::RIDX_W'(sm4_pkg::ROUNDS - 1))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_reg && !load)
        begin
            rk_reg[idx_reg] <= nk;
        end
    end

    assign busy       = run_reg;
    assign round_keys = rk_reg;

    `SM4_ASSERT_NEXT(a_load_runs, clk, rst_n, load, busy && idx_reg == '0)
    `SM4_ASSERT_NEXT(a_stop, clk, rst_n,
        run_reg && !load && idx_reg == sm4_pkg::RIDX_W'(sm4_pkg::ROUNDS - 1), !busy)
    `SM4_ASSERT_NEXT(a_idle_stays, clk, rst_n, !run_reg && !load, !busy)
endmodule
`default_nettype wire

/* design/sm4_block_cipher_unit.sv */
// Top level of the SM4 block cipher: configuration, key schedule and round pipeline.
// A word accepted with start passes through the 32 round cells and then the output
// register to result. Throughput: one word per cycle while busy is low, set by the
// row of 32 round cells that each hold one block in flight. After reset, and after
// any key write, the key schedule fills the 32 round keys with busy high.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none
`include "sm4_block_cipher_unit_defines.svh"
module sm4_block_cipher_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sm4_pkg::in_word_t  in_word,
    output logic                   result_valid,
    output sm4_pkg::out_word_t     result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_data
);
    localparam int R = sm4_pkg::ROUNDS;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        mode_reg;
    logic        cfg_fire;
    logic        key_load;
    logic        ks_busy;
    logic [31:0] round_keys [R];

    logic            cell_valid [R+1];
    sm4_pkg::state_t cell_data  [R+1];
    logic            cell_mode  [R+1];

    logic               out_valid_reg;
    sm4_pkg::out_word_t out_reg;
    sm4_pkg::state_t    fin;

    // Configuration is always taken; a key write restarts the schedule.
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign key_load  = cfg_fire && (cfg_index == sm4_pkg::REG_KEY_HIGH
                                 || cfg_index == sm4_pkg::REG_KEY_LOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            mode_reg     <= 1'b1;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                sm4_pkg::REG_KEY_HIGH:    key_high_reg <= cfg_data;
                sm4_pkg::REG_KEY_LOW:     key_low_reg  <= cfg_data;
                sm4_pkg::REG_CIPHER_MODE: mode_reg     <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    sm4_key_sched u_key_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (key_load),
        .key_high  (cfg_index == sm4_pkg::REG_KEY_HIGH ? cfg_data : key_high_reg),
        .key_low   (cfg_index == sm4_pkg::REG_KEY_LOW  ? cfg_data : key_low_reg),
        .busy      (ks_busy),
        .round_keys(round_keys)
    );

    // Words enter only while the round keys are complete.
    assign busy = ks_busy;

    assign cell_valid[0] = start && !busy;
    assign cell_data[0]  = {in_word.block_high, in_word.block_low};
    assign cell_mode[0]  = mode_reg;

    // Each cell picks its round key by the mode its word entered with.
    for (genvar i = 0; i < R; i++)
    begin : g_cell
        logic cmode_reg;

        sm4_round_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid    (cell_valid[i]),
            .data     (cell_data[i]),
            .round_key(cell_mode[i] ? round_keys[i] : round_keys[R-1-i]),
            .valid_out(cell_valid[i+1]),
            .data_out (cell_data[i+1])
        );

        always_ff @(posedge clk)
        begin
            if (cell_valid[i])
            begin
                cmode_reg <= cell_mode[i];
            end
        end
        assign cell_mode[i+1] = cmode_reg;
    end

    // Output words are the last four state words in reverse order.
    assign fin = cell_data[R];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cell_valid[R];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_valid[R])
        begin
            out_reg <= {fin.x3, fin.x2, fin.x1, fin.x0};
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `SM4_ASSERT_NEXT(a_load_busy, clk, rst_n, key_load, busy)
    `SM4_ASSERT_IMP(a_no_entry_busy, clk, rst_n, busy, !cell_valid[0])
    `SM4_ASSERT_NEXT(a_out_follows, clk, rst_n, cell_valid[R], result_valid)
endmodule
`default_nettype wire

/* dv/sm4_block_cipher_unit_checker.sv */
// Checker that predicts SM4 results from observed words and compares them with the DUT.
module sm4_block_cipher_unit_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire sm4_pkg::in_word_t   in_word,
    input  wire logic                result_valid,
    input  wire sm4_pkg::out_word_t  result,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [63:0]         cfg_data,
    output int                       fail_count,
    output int                       pending_count,
    output int                       blocks_checked
);
    localparam logic [7:0] SUBST [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    logic [63:0]        key_hi_q;
    logic [63:0]        key_lo_q;
    logic               encrypt_q;
    logic [31:0]        sched [sm4_pkg::ROUNDS];
    sm4_pkg::out_word_t cipher_fifo [$];

    function automatic logic [31:0] subst_word(input logic [31:0] v);
        return {SUBST[v[31:24]], SUBST[v[23:16]], SUBST[v[15:8]], SUBST[v[7:0]]};
    endfunction

    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic build_schedule();
        logic [31:0] k [4];
        logic [31:0] s;
        logic [31:0] ck;
        logic [31:0] nk;
        k[0] = key_hi_q[63:32] ^ 32'ha3b1bac6;
        k[1] = key_hi_q[31:0] ^ 32'h56aa3350;
        k[2] = key_lo_q[63:32] ^ 32'h677d9197;
        k[3] = key_lo_q[31:0] ^ 32'hb27022dc;
        for (int i = 0; i < sm4_pkg::ROUNDS; i++)
        begin
            for (int j = 0; j < 4; j++)
                ck[31 - 8 * j -: 8] = 8'((4 * i + j) * 7);
            s = subst_word(k[1] ^ k[2] ^ k[3] ^ ck);
            nk = k[0] ^ s ^ rol(s, 13) ^ rol(s, 23);
            sched[i] = nk;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
        end
    endtask

    function automatic sm4_pkg::out_word_t cipher_block(input sm4_pkg::in_word_t w);
        logic [31:0]        x [4];
        logic [31:0]        rk;
        logic [31:0]        b;
        logic [31:0]        nx;
        sm4_pkg::out_word_t r;
        x[0] = w.block_high[63:32];
        x[1] = w.block_high[31:0];
        x[2] = w.block_low[63:32];
        x[3] = w.block_low[31:0];
        for (int i = 0; i < sm4_pkg::ROUNDS; i++)
        begin
            rk = encrypt_q ? sched[i] : sched[sm4_pkg::ROUNDS - 1 - i];
            b = subst_word(x[1] ^ x[2] ^ x[3] ^ rk);
            nx = x[0] ^ b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
        end
        r.result_high = {x[3], x[2]};
        r.result_low = {x[1], x[0]};
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        blocks_checked = 0;
        key_hi_q = '0;
        key_lo_q = '0;
        encrypt_q = 1'b1;
        build_schedule();
    end

    always @(posedge clk)
    begin
        sm4_pkg::out_word_t exp_word;
        if (rst_n)
        begin
            // Results are checked before the new word of this edge is predicted.
            if (result_valid)
            begin
                if (cipher_fifo.size() == 0)
                begin
                    $error("result word with no expectation: %h", result);
                    fail_count++;
                end
                else
                begin
                    exp_word = cipher_fifo.pop_front();
                    blocks_checked++;
                    if (result.result_high !== exp_word.result_high)
                    begin
                        $error("result_high expected %h actual %h",
                               exp_word.result_high, result.result_high);
                        fail_count++;
                    end
                    if (result.result_low !== exp_word.result_low)
                    begin
                        $error("result_low expected %h actual %h",
                               exp_word.result_low, result.result_low);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                cipher_fifo.push_back(cipher_block(in_word));
            pending_count = cipher_fifo.size();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sm4_pkg::REG_KEY_HIGH:
                    begin
                        key_hi_q = cfg_data;
                        build_schedule();
                    end
                    sm4_pkg::REG_KEY_LOW:
                    begin
                        key_lo_q = cfg_data;
                        build_schedule();
                    end
                    sm4_pkg::REG_CIPHER_MODE: encrypt_q = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

/* dv/sm4_block_cipher_unit_tb.sv */
// Testbench top for the SM4 block cipher: stimulus, configuration phases and verdict.
module sm4_block_cipher_unit_tb;
    localparam int PIPE_LATENCY = 33;
    localparam int STALL_LIMIT = 2000;
    // An index past the last register; writes to it have no effect.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    sm4_pkg::in_word_t  in_word;
    logic               result_valid;
    sm4_pkg::out_word_t result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;
    int                 fail_count;
    int                 pending_count;
    int                 blocks_checked;
    int                 idle_cycles;
    int                 words_sent;
    int                 keys_written;

    sm4_block_cipher_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sm4_block_cipher_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .blocks_checked(blocks_checked)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // The watchdog restarts whenever a word, a result or a register write is accepted.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // A value that often sits at an extreme, so that corner keys and blocks recur.
    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    // Sends one word: start stays up until the block takes it at an edge with busy low.
    task automatic send_word(input logic [63:0] hi, input logic [63:0] lo);
        start <= 1'b1;
        in_word <= '{block_high: hi, block_low: lo};
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Register writes only happen once the pipeline has drained. The first edge lets
    // the checker count a word taken at the edge just passed.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        start <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == sm4_pkg::REG_KEY_HIGH || idx == sm4_pkg::REG_KEY_LOW)
            keys_written++;
    endtask

    // Random traffic in bursts; some phases run back to back without gaps.
    task automatic burst_traffic(input int count, input bit gaps);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                send_word(pick64(), pick64());
                left--;
            end
            if (gaps && $urandom_range(0, 2) != 0)
                idle_for($urandom_range(1, 40));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_index = sm4_pkg::REG_KEY_HIGH;
        cfg_data = '0;
        idle_cycles = 0;
        words_sent = 0;
        keys_written = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset key, extreme blocks, both modes, the standard test vector.
        send_word('0, '0);
        send_word('1, '1);
        send_word('1, '0);
        send_word('0, '1);
        send_word(64'h0123456789abcdef, 64'hfedcba9876543210);
        drain();
        write_reg(sm4_pkg::REG_KEY_HIGH, 64'h0123456789abcdef);
        write_reg(sm4_pkg::REG_KEY_LOW, 64'hfedcba9876543210);
        send_word(64'h0123456789abcdef, 64'hfedcba9876543210);
        send_word(64'h681edf34d206965e, 64'h86b3e94f536e4246);
        drain();
        write_reg(sm4_pkg::REG_CIPHER_MODE, 64'h0);
        send_word(64'h681edf34d206965e, 64'h86b3e94f536e4246);
        send_word('0, '1);
        drain();
        // Only bit 0 of the mode matters, and an unused index must be ignored.
        write_reg(sm4_pkg::REG_CIPHER_MODE, 64'hfffffffffffffffe);
        write_reg(REG_UNUSED, '1);
        send_word('1, '0);
        drain();
        write_reg(sm4_pkg::REG_CIPHER_MODE, '1);
        write_reg(sm4_pkg::REG_KEY_HIGH, '1);
        write_reg(sm4_pkg::REG_KEY_LOW, '1);
        send_word('0, '0);
        send_word('1, '1);
        drain();

        // Random phases: new mode each time, usually a new key, extremes among them.
        for (int phase = 0; phase < 12; phase++)
        begin
            drain();
            repeat (PIPE_LATENCY) @(posedge clk);
            if ($urandom_range(0, 3) != 0)
                write_reg(sm4_pkg::REG_KEY_HIGH, pick64());
            if ($urandom_range(0, 3) != 0)
                write_reg(sm4_pkg::REG_KEY_LOW, pick64());
            write_reg(sm4_pkg::REG_CIPHER_MODE, {$urandom(), $urandom()});
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_UNUSED, rand64());
            burst_traffic($urandom_range(120, 180), phase % 4 != 3);
        end
        drain();
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        $display("sent %0d words, checked %0d results, across %0d key writes and both modes",
                 words_sent, blocks_checked, keys_written);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
